// ===== hw/rtl/pcm_voice_mixer_32ch_top_assert.svh =====
// Assertion macros for the voice mixer top level
`ifndef PCM_VOICE_MIXER_32CH_TOP_ASSERT_SVH
`define PCM_VOICE_MIXER_32CH_TOP_ASSERT_SVH
// same-cycle implication
`define PVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/pvm_pkg.sv =====
// Types, constants and the mu-law expansion for the voice mixer
package pvm_pkg;
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_LOAD  = 2'd3;

  localparam logic [9:0] ADDR_CONTROL = 10'h200;
  localparam logic [9:0] ADDR_KEY     = 10'h202;

  localparam logic [2:0] REG_VOL_FRONT = 3'd0;
  localparam logic [2:0] REG_VOL_REAR  = 3'd1;
  localparam logic [2:0] REG_FREQ      = 3'd2;
  localparam logic [2:0] REG_FLAGS     = 3'd3;
  localparam logic [2:0] REG_BANK      = 3'd4;
  localparam logic [2:0] REG_START     = 3'd5;
  localparam logic [2:0] REG_END       = 3'd6;
  localparam logic [2:0] REG_LOOP      = 3'd7;

  // flag bit positions
  localparam int F_BUSY     = 15;
  localparam int F_KEYON    = 14;
  localparam int F_KEYOFF   = 13;
  localparam int F_LOOPHIST = 11;
  localparam int F_PHASE_RL = 9;
  localparam int F_PHASE_FL = 8;
  localparam int F_PHASE_FR = 7;
  localparam int F_LDIR     = 6;
  localparam int F_LINK     = 5;
  localparam int F_NOISE    = 4;
  localparam int F_MULAW    = 3;
  localparam int F_NOFILTER = 2;
  localparam int F_LOOP     = 1;
  localparam int F_REVERSE  = 0;

  localparam logic [15:0] LFSR_SEED = 16'h1234;
  localparam logic [15:0] LFSR_TAPS = 16'hfff6;
  localparam logic [16:0] ROM_SIZE_RESET = 17'h10000;

  typedef struct packed {
    logic [15:0] vol_front;
    logic [15:0] vol_rear;
    logic [15:0] freq;
    logic [15:0] bank;
    logic [15:0] wstart;
    logic [15:0] wend;
    logic [15:0] wloop;
  } static_row_t;

  typedef struct packed {
    logic [15:0]      flags;
    logic [31:0]      pos;
    logic [15:0]      phase;
    logic [15:0]      now;
    logic [15:0]      prev;
    logic [3:0][7:0]  vol;
  } dyn_row_t;

  localparam int STATIC_W = $bits(static_row_t);
  localparam int DYN_W    = $bits(dyn_row_t);

  // segment-wise mu-law expansion
  function automatic logic [15:0] mulaw(input logic [7:0] b);
    logic [6:0]  i;
    logic [9:0]  j;
    logic [15:0] v;
    i = b[6:0];
    if (i < 7'd16)       j = {3'd0, i};
    else if (i < 7'd24)  j = 10'd16 + {2'd0, i - 7'd16, 1'b0};
    else if (i < 7'd48)  j = 10'd32 + {1'b0, i - 7'd24, 2'd0};
    else if (i < 7'd100) j = 10'd128 + {i - 7'd48, 3'd0};
    else                 j = 10'd544 + {i[5:0] - 6'd36, 4'd0};
    v = {1'b0, j, 5'd0};
    if (b[7]) v = ~v & 16'hffe0;
    return v;
  endfunction

  function automatic logic [7:0] ramp(input logic [7:0] cur, input logic [7:0] tgt);
    if (cur > tgt)      return cur - 8'd1;
    else if (cur < tgt) return cur + 8'd1;
    else                return cur;
  endfunction
endpackage

// ===== hw/rtl/pvm_ifs.sv =====
// Request and result channel interfaces
interface pvm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  bus_address;
  logic [15:0] write_data;
  logic [15:0] rom_address;
  logic [7:0]  rom_byte;
  modport source (output valid, req_type, bus_address, write_data, rom_address, rom_byte,
                  input ready);
  modport sink (input valid, req_type, bus_address, write_data, rom_address, rom_byte,
                output ready);
endinterface

interface pvm_rsp_if;
  logic               valid;
  logic               ready;
  logic [15:0]        read_data;
  logic               sample_valid;
  logic signed [15:0] out_front_left;
  logic signed [15:0] out_front_right;
  logic signed [15:0] out_rear_left;
  logic signed [15:0] out_rear_right;
  modport source (output valid, read_data, sample_valid, out_front_left, out_front_right,
                  out_rear_left, out_rear_right, input ready);
  modport sink (input valid, read_data, sample_valid, out_front_left, out_front_right,
                out_rear_left, out_rear_right, output ready);
endinterface

// ===== hw/rtl/pvm_voice_ram.sv =====
// Per-voice row memory, one write and one registered read port
module pvm_voice_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/pvm_sample_ram.sv =====
// Sample byte memory, one write and one registered read port
module pvm_sample_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [7:0]           wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [7:0]           rdata
);
  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/pcm_voice_mixer_32ch_top.sv =====
// Loads, control and unmapped accesses go straight to S_DONE; voice register reads/writes pass
// through S_BRD or S_BMOD; key execute walks every voice through S_KRD and S_KWR.
// Tick: one voice row at a time through the voice memories
// (read, fetch, update, interpolate, weight, accumulate).
// One request in flight; the next request is taken while a result waits on rsp.
// Synchronous reset, then a clearing pass over the voice memories before the first request
// is taken; the rom_size register accepts writes throughout.
module pcm_voice_mixer_32ch_top
  import pvm_pkg::*;
#(
  parameter int VOICE_COUNT      = 32,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  pvm_req_if.sink     req,
  pvm_rsp_if.source   rsp
);
  localparam int VIW = VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BMOD, S_BRD, S_KRD, S_KWR,
    S_TRD, S_T1, S_T2, S_T3, S_T4, S_T5, S_DONE
  } state_t;

  state_t      state;
  logic [VIW-1:0] cnt;
  logic [VIW-1:0] vsel_q;
  logic [2:0]  reg_q;
  logic [15:0] data_q;
  logic [16:0] rom_size;
  logic [15:0] control_word;
  logic [15:0] lfsr;

  static_row_t st_rd, stq, st_wd;
  dyn_row_t    dy_rd, dq, nd, nd_c, kd_c, dy_wd;
  logic        st_we, dy_we;
  logic [VIW-1:0] raddr, waddr;
  logic [7:0]  smp_rd;
  logic        smp_we;

  logic [16:0] nxt, nxt_q;
  logic        busy_q, fetch_q, ramp_q, posok_q;
  logic [15:0] lfsr_c;

  logic signed [33:0] prod_c;
  logic [15:0] prod_hi, s_now, s_last, fl3;
  logic        nofilt3, busy3;
  logic [3:0][7:0] vol3;
  logic [3:0][17:0] term_c, term_q;
  logic [3:0][23:0] acc;

  logic [15:0] res_read;
  logic        res_sv;
  logic [3:0][15:0] res_out;

  logic [4:0]  vin;
  logic        vin_ok;
  logic        accept;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign vin = req.bus_address[7:3];
  assign vin_ok = (req.bus_address[9:8] == 2'd0) && ({1'b0, vin} < 6'(VOICE_COUNT));

  assign raddr = (state == S_IDLE) ? vin[VIW-1:0] : cnt;
  assign waddr = (state == S_BMOD) ? vsel_q : cnt;

  pvm_voice_ram #(.DEPTH(VOICE_COUNT), .WIDTH(STATIC_W)) u_static_ram (
    .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wd), .raddr(raddr), .rdata(st_rd)
  );
  pvm_voice_ram #(.DEPTH(VOICE_COUNT), .WIDTH(DYN_W)) u_dyn_ram (
    .clk(clk), .we(dy_we), .waddr(waddr), .wdata(dy_wd), .raddr(raddr), .rdata(dy_rd)
  );

  assign smp_we = accept && (req.req_type == REQ_LOAD);
  pvm_sample_ram #(.ADDR_BITS(SAMPLE_ADDR_BITS)) u_sample_ram (
    .clk(clk), .we(smp_we), .waddr(SAMPLE_ADDR_BITS'(req.rom_address)),
    .wdata(req.rom_byte), .raddr(SAMPLE_ADDR_BITS'(dy_rd.pos)), .rdata(smp_rd)
  );

  assign nxt = {1'b0, dy_rd.phase} + {1'b0, st_rd.freq};
  assign lfsr_c = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);

  // memory write port selection
  always_comb begin
    st_we = 1'b0;
    dy_we = 1'b0;
    st_wd = st_rd;
    dy_wd = dy_rd;
    case (state)
      S_CLEAR: begin
        st_we = 1'b1;
        dy_we = 1'b1;
        st_wd = '0;
        dy_wd = '0;
      end
      S_BMOD: begin
        if (reg_q == REG_FLAGS) begin
          dy_we = 1'b1;
          dy_wd.flags = data_q;
        end else begin
          st_we = 1'b1;
          case (reg_q)
            REG_VOL_FRONT: st_wd.vol_front = data_q;
            REG_VOL_REAR:  st_wd.vol_rear  = data_q;
            REG_FREQ:      st_wd.freq      = data_q;
            REG_BANK:      st_wd.bank      = data_q;
            REG_START:     st_wd.wstart    = data_q;
            REG_END:       st_wd.wend      = data_q;
            default:       st_wd.wloop     = data_q;
          endcase
        end
      end
      S_KWR: begin
        dy_we = 1'b1;
        dy_wd = kd_c;
      end
      S_T3: begin
        dy_we = 1'b1;
        dy_wd = nd;
      end
      default: ;
    endcase
  end

  // key execute for one voice
  always_comb begin
    kd_c = dy_rd;
    if (kd_c.flags[F_KEYON]) begin
      kd_c.pos = {st_rd.bank, st_rd.wstart};
      kd_c.now = '0;
      kd_c.prev = '0;
      kd_c.phase = 16'hffff;
      kd_c.flags[F_BUSY] = 1'b1;
      kd_c.flags[F_KEYON] = 1'b0;
      kd_c.flags[F_LOOPHIST] = 1'b0;
      kd_c.vol = '0;
    end
    if (kd_c.flags[F_KEYOFF]) begin
      kd_c.flags[F_BUSY] = 1'b0;
      kd_c.flags[F_KEYOFF] = 1'b0;
      kd_c.phase = 16'hffff;
    end
  end

  // fetch, loop handling, ramp and phase update
  always_comb begin
    logic [7:0]  b;
    logic [15:0] low;
    nd_c = dq;
    b = posok_q ? smp_rd : 8'h00;
    low = dq.pos[15:0];
    if (fetch_q) begin
      nd_c.prev = dq.now;
      if (dq.flags[F_NOISE]) begin
        nd_c.now = lfsr_c;
      end else begin
        nd_c.now = dq.flags[F_MULAW] ? mulaw(b) : {b, 8'h00};
        if (dq.flags[F_LOOP] && dq.flags[F_REVERSE]) begin
          if (dq.flags[F_LDIR] && low == stq.wloop) nd_c.flags[F_LDIR] = 1'b0;
          else if (!dq.flags[F_LDIR] && low == stq.wend) nd_c.flags[F_LDIR] = 1'b1;
          nd_c.pos = nd_c.flags[F_LDIR] ? dq.pos - 32'd1 : dq.pos + 32'd1;
        end else if (low == stq.wend) begin
          if (dq.flags[F_LINK] && dq.flags[F_LOOP]) begin
            nd_c.pos = {stq.wstart, stq.wloop};
            nd_c.flags[F_LOOPHIST] = 1'b1;
          end else if (dq.flags[F_LOOP]) begin
            nd_c.pos = {8'h00, dq.pos[23:16], stq.wloop};
            nd_c.flags[F_LOOPHIST] = 1'b1;
          end else begin
            nd_c.flags[F_KEYOFF] = 1'b1;
            nd_c.flags[F_BUSY] = 1'b0;
            nd_c.now = '0;
          end
        end else begin
          nd_c.pos = dq.flags[F_REVERSE] ? dq.pos - 32'd1 : dq.pos + 32'd1;
        end
      end
    end
    if (ramp_q) begin
      nd_c.vol[0] = ramp(dq.vol[0], stq.vol_front[15:8]);
      nd_c.vol[1] = ramp(dq.vol[1], stq.vol_front[7:0]);
      nd_c.vol[2] = ramp(dq.vol[2], stq.vol_rear[15:8]);
      nd_c.vol[3] = ramp(dq.vol[3], stq.vol_rear[7:0]);
    end
    if (busy_q) nd_c.phase = nxt_q[15:0];
  end

  // interpolation product: phase * (now - last); bits 31:16 are registered as prod_hi
  always_comb begin
    logic signed [16:0] diff;
    diff = {nd.now[15], nd.now} - {nd.prev[15], nd.prev};
    prod_c = $signed({1'b0, nd.phase}) * diff;
  end

  // weighted terms, floor of product / 256
  always_comb begin
    logic [15:0]        s;
    logic signed [16:0] sn;
    logic signed [25:0] p;
    logic               inv;
    s = busy3 ? (nofilt3 ? s_now : s_last + prod_hi) : 16'h0000;
    for (int c = 0; c < 4; c++) begin
      case (c)
        0:       inv = fl3[F_PHASE_FL];
        2:       inv = fl3[F_PHASE_RL];
        default: inv = fl3[F_PHASE_FR];
      endcase
      sn = inv ? -$signed({s[15], s}) : $signed({s[15], s});
      p = sn * $signed({1'b0, vol3[c]});
      term_c[c] = 18'(p >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      rom_size <= ROM_SIZE_RESET;
      control_word <= '0;
      lfsr <= LFSR_SEED;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) rom_size <= cfg_data;
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (cnt == LAST_VOICE) begin
            cnt <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            vsel_q <= vin[VIW-1:0];
            reg_q <= req.bus_address[2:0];
            data_q <= req.write_data;
            res_read <= '0;
            res_sv <= 1'b0;
            res_out <= '0;
            cnt <= '0;
            acc <= '0;
            state <= S_DONE;
            case (req.req_type)
              REQ_WRITE: begin
                if (vin_ok) state <= S_BMOD;
                else if (req.bus_address == ADDR_CONTROL) control_word <= req.write_data;
                else if (req.bus_address == ADDR_KEY) state <= S_KRD;
              end
              REQ_READ: begin
                if (vin_ok) state <= S_BRD;
                else if (req.bus_address == ADDR_CONTROL) res_read <= control_word;
              end
              REQ_TICK: state <= S_TRD;
              default: ;
            endcase
          end
        end
        S_BMOD: state <= S_DONE;
        S_BRD: begin
          case (reg_q)
            REG_VOL_FRONT: res_read <= st_rd.vol_front;
            REG_VOL_REAR:  res_read <= st_rd.vol_rear;
            REG_FREQ:      res_read <= st_rd.freq;
            REG_FLAGS:     res_read <= dy_rd.flags;
            REG_BANK:      res_read <= st_rd.bank;
            REG_START:     res_read <= st_rd.wstart;
            REG_END:       res_read <= st_rd.wend;
            default:       res_read <= st_rd.wloop;
          endcase
          state <= S_DONE;
        end
        S_KRD: state <= S_KWR;
        S_KWR: begin
          if (cnt == LAST_VOICE) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_KRD;
          end
        end
        S_TRD: state <= S_T1;
        S_T1: begin
          stq <= st_rd;
          dq <= dy_rd;
          nxt_q <= nxt;
          busy_q <= dy_rd.flags[F_BUSY];
          fetch_q <= dy_rd.flags[F_BUSY] && nxt[16];
          ramp_q <= dy_rd.flags[F_BUSY] && (nxt[16] || (nxt[15] ^ dy_rd.phase[15]));
          posok_q <= (dy_rd.pos < {15'd0, rom_size}) &&
                     ((dy_rd.pos >> SAMPLE_ADDR_BITS) == 32'd0);
          state <= S_T2;
        end
        S_T2: begin
          nd <= nd_c;
          if (fetch_q && dq.flags[F_NOISE]) lfsr <= lfsr_c;
          state <= S_T3;
        end
        S_T3: begin
          prod_hi <= prod_c[31:16];
          s_now <= nd.now;
          s_last <= nd.prev;
          nofilt3 <= nd.flags[F_NOFILTER];
          busy3 <= busy_q;
          fl3 <= nd.flags;
          vol3 <= nd.vol;
          state <= S_T4;
        end
        S_T4: begin
          term_q <= term_c;
          state <= S_T5;
        end
        S_T5: begin
          for (int c = 0; c < 4; c++) acc[c] <= acc[c] + 24'(signed'(term_q[c]));
          if (cnt == LAST_VOICE) begin
            res_sv <= 1'b1;
            for (int c = 0; c < 4; c++) res_out[c] <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_TRD;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.read_data <= res_read;
            rsp.sample_valid <= res_sv;
            rsp.out_front_left <= res_sv ? acc[0][18:3] : res_out[0];
            rsp.out_front_right <= res_sv ? acc[1][18:3] : res_out[1];
            rsp.out_rear_left <= res_sv ? acc[2][18:3] : res_out[2];
            rsp.out_rear_right <= res_sv ? acc[3][18:3] : res_out[3];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "pcm_voice_mixer_32ch_top_assert.svh"

  `PVM_ASSERT_NEXT(a_tick_starts, accept && req.req_type == REQ_TICK, state == S_TRD, "tick did not start voice walk")
  `PVM_ASSERT_NOW(a_no_write_idle, state == S_IDLE, !st_we && !dy_we, "voice memory written while idle")
  `PVM_ASSERT_NEXT(a_last_voice_done, state == S_T5 && cnt == LAST_VOICE, state == S_DONE, "tick walk overran last voice")
endmodule
